>>> src/canvas_pixel_sha256_hasher_core_defines.svh
// Assertion macros for the canvas pixel hasher checker.
// Used by the checker file only; expects clk and rst_n in scope.
`ifndef CANVAS_PIXEL_SHA256_HASHER_CORE_DEFINES_SVH
`define CANVAS_PIXEL_SHA256_HASHER_CORE_DEFINES_SVH

// same-cycle implication
`define CPH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/cph_pkg.sv
// Shared types, constants and tables for the canvas pixel SHA-256 hasher.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package cph_pkg;

  localparam int MAX_DIMENSION_BITS = 16;
  localparam logic [31:0] DIM_MASK = (MAX_DIMENSION_BITS >= 32) ? 32'hFFFF_FFFF :
                                     ((32'd1 << MAX_DIMENSION_BITS) - 32'd1);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // input function codes
  typedef enum logic [1:0] {
    FN_PREFIX = 2'd0,
    FN_PIXEL  = 2'd1,
    FN_FINISH = 2'd2
  } func_t;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // where the next hashed byte comes from
  typedef enum logic [2:0] {
    SRC_PRE,
    SRC_HDR,
    SRC_PIX,
    SRC_P80,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic        load;     // latch input payload
    logic        feed;     // hash one byte
    byte_src_t   src;
    logic [2:0]  bidx;     // byte position within the source
    logic        round;    // one compression round
    logic [5:0]  rnd;
    logic        add;      // fold working vars into chain
    logic        restart;  // back to initial hash, length zero
    logic [1:0]  oidx;     // digest word selected for output
  } cph_cmd_t;

  typedef struct packed {
    logic [5:0] len_low;   // message length mod 64
  } cph_sts_t;

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

>>> src/cph_if.sv
// Channel interfaces of the hasher: input items, digest words, config writes.
// No dependencies.
`default_nettype none
interface cph_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  prefix_byte;
  logic [31:0] pixel_rgba;
  modport source (output valid, func, prefix_byte, pixel_rgba, input ready);
  modport sink   (input valid, func, prefix_byte, pixel_rgba, output ready);
endinterface

interface cph_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

interface cph_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/cph_datapath.sv
// Hasher datapath: byte assembly, message schedule, rounds, chain, length.
// Depends on cph_pkg; driven by cph_ctrl commands.
`default_nettype none
module cph_datapath import cph_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cph_cmd_t    cmd,
  output cph_sts_t         sts,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [7:0]  prefix_byte,
  input  wire logic [31:0] pixel_rgba,
  output logic [63:0]      digest_word
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [15:0] width_r, height_r;
  logic [7:0]  pre_r;
  logic [31:0] pix_r;
  logic [63:0] len_r, bits_r;
  logic [23:0] acc_r;
  logic [31:0] w_r [16];
  logic [31:0] chain_r [8];
  logic [31:0] wk_r [8];

  logic [7:0]  byte_v;
  logic [31:0] dim_v;
  logic [31:0] t1, t2, wnew, s0, s1;

  assign sts.len_low = len_r[5:0];
  assign digest_word = {chain_r[{cmd.oidx, 1'b0}], chain_r[{cmd.oidx, 1'b1}]};

  // byte selection
  always_comb begin
    dim_v  = cmd.bidx[2] ? ({16'd0, height_r} & DIM_MASK) : ({16'd0, width_r} & DIM_MASK);
    byte_v = 8'd0;
    case (cmd.src)
      SRC_PRE: byte_v = pre_r;
      SRC_HDR: byte_v = dim_v[{cmd.bidx[1:0], 3'b000} +: 8];
      SRC_PIX: byte_v = pix_r[{cmd.bidx[1:0], 3'b000} +: 8];
      SRC_P80: byte_v = PAD_BYTE;
      SRC_LEN: byte_v = bits_r[{~cmd.bidx, 3'b000} +: 8];
      default: byte_v = 8'd0;
    endcase
  end

  // round logic
  always_comb begin
    t1 = wk_r[7] + (rotr(wk_r[4], 6) ^ rotr(wk_r[4], 11) ^ rotr(wk_r[4], 25))
       + ((wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6])) + K_TAB[cmd.rnd] + w_r[0];
    t2 = (rotr(wk_r[0], 2) ^ rotr(wk_r[0], 13) ^ rotr(wk_r[0], 22))
       + ((wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]));
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
  end

  // config registers, length and chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd0;
      height_r <= 16'd0;
      len_r    <= 64'd0;
      for (int i = 0; i < 8; i++) chain_r[i] <= IV_TAB[i];
    end else begin
      if (cfg_we && cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_we && cfg_index == REG_HEIGHT) height_r <= cfg_data;
      if (cmd.feed) len_r <= len_r + 64'd1;
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + wk_r[i];
      end
      if (cmd.restart) begin
        len_r <= 64'd0;
        for (int i = 0; i < 8; i++) chain_r[i] <= IV_TAB[i];
      end
    end
  end

  // payload: input latch, schedule, working variables
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pre_r <= prefix_byte;
      pix_r <= (pixel_rgba[31:24] == 8'd0) ? 32'd0 : pixel_rgba;
    end
    if (cmd.feed) begin
      acc_r <= {acc_r[15:0], byte_v};
      if (cmd.src == SRC_P80) bits_r <= {len_r[60:0], 3'b000};
      if (len_r[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
        w_r[15] <= {acc_r, byte_v};
      end
      // block completes with this byte: start a compression
      if (len_r[5:0] == 6'd63) begin
        for (int i = 0; i < 8; i++) wk_r[i] <= chain_r[i];
      end
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wnew;
      wk_r[7] <= wk_r[6];
      wk_r[6] <= wk_r[5];
      wk_r[5] <= wk_r[4];
      wk_r[4] <= wk_r[3] + t1;
      wk_r[3] <= wk_r[2];
      wk_r[2] <= wk_r[1];
      wk_r[1] <= wk_r[0];
      wk_r[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

>>> src/cph_ctrl.sv
// Hasher controller: sequences bytes, compression rounds and digest output.
// Depends on cph_pkg; commands cph_datapath.
`default_nettype none
module cph_ctrl import cph_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_func,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      word_index,
  output logic            last_word,
  input  wire cph_sts_t   sts,
  output cph_cmd_t        cmd
);

  typedef enum logic [2:0] {S_IDLE, S_FEED, S_COMP, S_ADD, S_OUT} state_t;
  typedef enum logic [2:0] {
    PH_PRE, PH_HDR, PH_PIX, PH_PAD80, PH_PADZ, PH_LEN, PH_END, PH_EMIT
  } phase_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt, ap;
  logic [2:0] cnt_r, cnt_nxt, ac;
  logic [5:0] rnd_r, rnd_nxt;
  logic [1:0] oidx_r, oidx_nxt;
  logic       hdr_r, hdr_nxt, pix_r, pix_nxt;
  state_t     disp;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign word_index = oidx_r;
  assign last_word  = (oidx_r == 2'd3);

  // command decode
  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.feed    = (state_r == S_FEED);
    cmd.bidx    = cnt_r;
    cmd.round   = (state_r == S_COMP);
    cmd.rnd     = rnd_r;
    cmd.add     = (state_r == S_ADD);
    cmd.restart = out_valid && out_ready && last_word;
    cmd.oidx    = oidx_r;
    unique case (phase_r)
      PH_PRE:   cmd.src = SRC_PRE;
      PH_HDR:   cmd.src = SRC_HDR;
      PH_PIX:   cmd.src = SRC_PIX;
      PH_PAD80: cmd.src = SRC_P80;
      PH_LEN:   cmd.src = SRC_LEN;
      default:  cmd.src = SRC_ZERO;
    endcase
  end

  // next phase after the byte being fed
  always_comb begin
    ap      = phase_r;
    ac      = cnt_r + 3'd1;
    hdr_nxt = hdr_r;
    unique case (phase_r)
      PH_PRE: ap = PH_END;
      PH_HDR: if (cnt_r == 3'd7) begin
        ap      = pix_r ? PH_PIX : PH_PAD80;
        ac      = 3'd0;
        hdr_nxt = (state_r == S_FEED) ? 1'b1 : hdr_r;
      end
      PH_PIX: if (cnt_r == 3'd3) ap = PH_END;
      PH_PAD80, PH_PADZ: begin
        ap = (sts.len_low == 6'd55) ? PH_LEN : PH_PADZ;
        ac = 3'd0;
      end
      PH_LEN: if (cnt_r == 3'd7) ap = PH_EMIT;
      default: ap = phase_r;
    endcase
  end

  // sequencing
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    pix_nxt   = pix_r;
    unique case (state_r == S_FEED ? ap : phase_r)
      PH_END:  disp = S_IDLE;
      PH_EMIT: disp = S_OUT;
      default: disp = S_FEED;
    endcase
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cnt_nxt  = 3'd0;
        oidx_nxt = 2'd0;
        pix_nxt  = (in_func == FN_PIXEL);
        case (in_func)
          FN_PREFIX: begin phase_nxt = PH_PRE; state_nxt = S_FEED; end
          FN_PIXEL:  begin phase_nxt = hdr_r ? PH_PIX : PH_HDR; state_nxt = S_FEED; end
          FN_FINISH: begin phase_nxt = hdr_r ? PH_PAD80 : PH_HDR; state_nxt = S_FEED; end
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_FEED: begin
        phase_nxt = ap;
        cnt_nxt   = ac;
        rnd_nxt   = 6'd0;
        state_nxt = (sts.len_low == 6'd63) ? S_COMP : disp;
      end
      S_COMP: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_ADD;
      end
      S_ADD: state_nxt = disp;
      S_OUT: if (out_ready) begin
        oidx_nxt = oidx_r + 2'd1;
        if (last_word) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_END;
      cnt_r   <= 3'd0;
      rnd_r   <= 6'd0;
      oidx_r  <= 2'd0;
      hdr_r   <= 1'b0;
      pix_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      pix_r   <= pix_nxt;
      hdr_r   <= cmd.restart ? 1'b0 : hdr_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/canvas_pixel_sha256_hasher_core.sv
// Items: each accepted item hashes its bytes one per cycle (prefix 1, pixel 4, header 8
// once); each completed 64-byte block then pauses feeding for 64 rounds and one fold.
// Flow: one item at a time; no new item is accepted until the current one is done.
// Finish: padding bytes, one or two blocks, then four digest words, one per accepted cycle.
// Reset (rst_n low, synchronous): width/height zero, chain at initial hash, length zero.
`default_nettype none
module canvas_pixel_sha256_hasher_core import cph_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cph_in_if.sink    in_s,
  cph_out_if.source out_s,
  cph_cfg_if.sink   cfg_s
);

  cph_cmd_t cmd;
  cph_sts_t sts;

  assign cfg_s.ready = 1'b1;

  cph_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_s.valid),
    .in_func    (in_s.func),
    .in_ready   (in_s.ready),
    .out_valid  (out_s.valid),
    .out_ready  (out_s.ready),
    .word_index (out_s.word_index),
    .last_word  (out_s.last_word),
    .sts        (sts),
    .cmd        (cmd)
  );

  cph_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_s.valid),
    .cfg_index   (cfg_s.index),
    .cfg_data    (cfg_s.data),
    .prefix_byte (in_s.prefix_byte),
    .pixel_rgba  (in_s.pixel_rgba),
    .digest_word (out_s.digest_word)
  );

endmodule
`default_nettype wire

>>> src/cph_checker.sv
// Port-level checks for the hasher top level, attached by bind.
// Depends on canvas_pixel_sha256_hasher_core_defines.svh.
`include "canvas_pixel_sha256_hasher_core_defines.svh"
`default_nettype none
module cph_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] digest_word,
  input wire logic [1:0]  word_index,
  input wire logic        last_word
);

  // digest words come in order without gaps
  `CPH_ASSERT_NXT(a_word_seq, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 2'd1), "digest word sequence broken")
  // last flag marks word three only
  `CPH_ASSERT_NOW(a_last, out_valid, last_word == (word_index == 2'd3), "last_word mismatch")
  // no new item while the digest is out
  `CPH_ASSERT_NOW(a_busy, out_valid, !in_ready, "input accepted during digest output")
  // stalled word holds
  `CPH_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(digest_word), "stalled digest word changed")

endmodule

bind canvas_pixel_sha256_hasher_core cph_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_s.ready),
  .out_valid   (out_s.valid),
  .out_ready   (out_s.ready),
  .digest_word (out_s.digest_word),
  .word_index  (out_s.word_index),
  .last_word   (out_s.last_word)
);
`default_nettype wire
